// File: hdl/masg_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the restoring division step for the share generator
// no dependencies

package masg_pkg;

	localparam int XW = 62;             // secret, residue and mask width
	localparam int KW = 64;             // key word port width
	localparam int PW = XW + 1;         // effective modulus width (zero modulus means 2^62)
	localparam int SW = XW + 1;         // width of x + t
	localparam int WORD_BITS_DEF = 64;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = XW;

	localparam logic [CFG_IDX_W-1:0] REG_MODULUS   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES = CFG_IDX_W'(1);

	localparam logic [XW-1:0] MODULUS_RST   = XW'(64'd2305843009213693951);
	localparam logic [3:0]    KEY_BYTES_RST = 4'd8;
	localparam logic [3:0]    KEY_BYTES_MAX = 4'd8;

	typedef struct packed {
		logic [XW-1:0] secret_value;
		logic [KW-1:0] key_word;
		logic [7:0]    flip_byte;
	} in_t;

	typedef struct packed {
		logic          share_bit;
		logic [XW-1:0] share_residue;
		logic [XW-1:0] mask_value;
		logic          flip_bit;
	} out_t;

	// one item as it waits between front and back
	typedef struct packed {
		logic [XW-1:0] x;
		logic [KW-1:0] word;
		logic          b;
	} entry_t;

	// shift in one dividend bit, subtract the divisor if it fits; returns {quotient bit, remainder}
	function automatic logic [XW:0] div_step(input logic [XW-1:0] rem, input logic din,
			input logic [PW-1:0] p);
		logic [PW-1:0] tmp;
		logic [PW-1:0] diff;
		tmp = {rem, din};
		diff = tmp - p;
		if (tmp >= p)
			return {1'b1, diff[XW-1:0]};
		else
			return {1'b0, tmp[XW-1:0]};
	endfunction

endpackage

// File: hdl/masg_if.sv
`timescale 1ns / 1ps
// valid/ready channels for input items and result items
// depends on masg_pkg

interface masg_in_if import masg_pkg::*; ();
	logic valid;
	logic ready;
	in_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface masg_out_if import masg_pkg::*; ();
	logic valid;
	logic ready;
	out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/masg_front.sv
`timescale 1ns / 1ps
// front end: takes input transfers, cuts the key word to the used bytes
// depends on masg_pkg and masg_if

module masg_front import masg_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	masg_in_if.sink      in_ch,
	input  logic [3:0]   key_bytes,
	input  logic         full,
	output logic         push,
	output entry_t       entry
);

	logic [3:0]    nb;
	logic [KW-1:0] kmask;

	assign nb = (key_bytes > KEY_BYTES_MAX) ? KEY_BYTES_MAX : key_bytes;

	always_comb begin
		for (int j = 0; j < KW / 8; j++) begin
			kmask[j*8 +: 8] = (4'(j) < nb) ? 8'hff : 8'h00;
		end
		for (int j = WORD_BITS; j < KW; j++) begin
			kmask[j] = 1'b0;
		end
	end

	assign in_ch.ready = !full;
	assign push = in_ch.valid && !full;
	assign entry.x = in_ch.data.secret_value;
	assign entry.word = in_ch.data.key_word & kmask;
	assign entry.b = in_ch.data.flip_byte[0];

endmodule

// File: hdl/masg_queue.sv
`timescale 1ns / 1ps
// two-entry queue between front and back
// depends on masg_pkg

module masg_queue import masg_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t din,
	input  logic   pop,
	output logic   full,
	output logic   not_empty,
	output entry_t dout
);

	entry_t     mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       do_pop;

	assign full = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign do_pop = pop && not_empty;
	assign dout = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (do_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= din;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("queue push while full");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");

endmodule

// File: hdl/masg_back.sv
`timescale 1ns / 1ps
// back end: pipelined restoring division, first for the mask t, then for x + t
// depends on masg_pkg and masg_if

module masg_back import masg_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [PW-1:0] p_eff,
	input  logic          q_not_empty,
	input  entry_t        q_dout,
	output logic          pop,
	masg_out_if.source    out_ch
);

	typedef struct packed {
		logic          valid;
		logic [XW-1:0] rem;
		logic [KW-1:0] word;
		logic [XW-1:0] x;
		logic          b;
	} a_stage_t;

	typedef struct packed {
		logic          valid;
		logic [XW-1:0] rem;
		logic [SW-1:0] sum;
		logic [XW-1:0] t;
		logic          b;
		logic          qb;
	} b_stage_t;

	a_stage_t a_s [0:WORD_BITS];
	b_stage_t b_s [0:SW];
	logic     en;

	assign en = !b_s[SW].valid || out_ch.ready;
	assign pop = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_s[0].valid <= 1'b0;
		end else if (en) begin
			a_s[0].valid <= q_not_empty;
			a_s[0].rem <= '0;
			a_s[0].word <= q_dout.word;
			a_s[0].x <= q_dout.x;
			a_s[0].b <= q_dout.b;
		end
	end

	for (genvar k = 0; k < WORD_BITS; k++) begin : g_mask
		logic [XW:0] st;
		assign st = div_step(a_s[k].rem, a_s[k].word[WORD_BITS-1], p_eff);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				a_s[k+1].valid <= 1'b0;
			end else if (en) begin
				a_s[k+1].valid <= a_s[k].valid;
				a_s[k+1].rem <= st[XW-1:0];
				a_s[k+1].word <= a_s[k].word << 1;
				a_s[k+1].x <= a_s[k].x;
				a_s[k+1].b <= a_s[k].b;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_s[0].valid <= 1'b0;
		end else if (en) begin
			b_s[0].valid <= a_s[WORD_BITS].valid;
			b_s[0].rem <= '0;
			b_s[0].sum <= SW'(a_s[WORD_BITS].x) + SW'(a_s[WORD_BITS].rem);
			b_s[0].t <= a_s[WORD_BITS].rem;
			b_s[0].b <= a_s[WORD_BITS].b;
			b_s[0].qb <= 1'b0;
		end
	end

	for (genvar k = 0; k < SW; k++) begin : g_share
		logic [XW:0] st;
		assign st = div_step(b_s[k].rem, b_s[k].sum[SW-1], p_eff);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				b_s[k+1].valid <= 1'b0;
			end else if (en) begin
				b_s[k+1].valid <= b_s[k].valid;
				b_s[k+1].rem <= st[XW-1:0];
				b_s[k+1].sum <= b_s[k].sum << 1;
				b_s[k+1].t <= b_s[k].t;
				b_s[k+1].b <= b_s[k].b;
				b_s[k+1].qb <= st[XW];
			end
		end
	end

	assign out_ch.valid = b_s[SW].valid;
	assign out_ch.data.share_bit = b_s[SW].qb ^ b_s[SW].b;
	assign out_ch.data.share_residue = b_s[SW].rem;
	assign out_ch.data.mask_value = b_s[SW].t;
	assign out_ch.data.flip_bit = b_s[SW].b;

	a_residue_range: assert property (@(posedge clk) disable iff (!arst_n)
			b_s[SW].valid |-> (PW'(b_s[SW].rem) < p_eff))
		else $error("residue not below modulus");
	a_mask_range: assert property (@(posedge clk) disable iff (!arst_n)
			b_s[SW].valid |-> (PW'(b_s[SW].t) < p_eff))
		else $error("mask not below modulus");
	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
			b_s[0].valid |-> (b_s[0].sum == SW'(b_s[0].t) + SW'(b_s[0].sum - SW'(b_s[0].t))))
		else $error("sum stage inconsistent");

endmodule

// File: hdl/modular_additive_share_gen_core.sv
`timescale 1ns / 1ps
// top level of the modular additive share generator
// depends on masg_pkg, masg_if, masg_front, masg_queue, masg_back
//
// channel   dir   payload                                          handshake
// in_ch     in    secret_value, key_word, flip_byte                valid/ready
// out_ch    out   share_bit, share_residue, mask_value, flip_bit   valid/ready
// cfg       in    cfg_we, cfg_index, cfg_data                      write enable only
//
// one item per cycle sustained while the output is not stalled; from input transfer
// to result an item passes the front queue, WORD_BITS mask division steps, one add and 63 share steps
// each division step stage does one compare-and-subtract of the restoring divider
// reset clears the queue and all stage valid bits, modulus returns to 2^61-1, key bytes to 8
// a stalled output freezes the whole back pipeline; the two-entry queue keeps the
// front accepting until the queue is full

module modular_additive_share_gen_core import masg_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	masg_in_if.sink               in_ch,
	masg_out_if.source            out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [XW-1:0] modulus_q;
	logic [3:0]    key_bytes_q;
	logic [PW-1:0] p_eff;

	// front to queue
	logic          push;
	logic          full;
	entry_t        entry;

	// queue to back
	logic          pop;
	logic          not_empty;
	entry_t        q_dout;

	// configuration registers; the user writes them only while the block is idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RST;
			key_bytes_q <= KEY_BYTES_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODULUS:   modulus_q <= cfg_data;
				REG_KEY_BYTES: key_bytes_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// a zero modulus stands for 2^62
	assign p_eff = (modulus_q == '0) ? {1'b1, {XW{1'b0}}} : {1'b0, modulus_q};

	masg_front #(.WORD_BITS(WORD_BITS)) u_front (
		.in_ch     (in_ch),
		.key_bytes (key_bytes_q),
		.full      (full),
		.push      (push),
		.entry     (entry)
	);

	masg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.din       (entry),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.dout      (q_dout)
	);

	masg_back #(.WORD_BITS(WORD_BITS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.p_eff       (p_eff),
		.q_not_empty (not_empty),
		.q_dout      (q_dout),
		.pop         (pop),
		.out_ch      (out_ch)
	);

endmodule

// File: test/modular_additive_share_gen_core_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the modular additive share generator core
// depends on masg_pkg, masg_if and the core rtl

module modular_additive_share_gen_core_tb;
	import masg_pkg::*;

	localparam int LATENCY = WORD_BITS_DEF + 70;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	masg_in_if in_ch ();
	masg_out_if out_ch ();

	modular_additive_share_gen_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor copy of the two registers
	logic [XW-1:0] prime_reg;
	logic [3:0] nbytes_reg;

	in_t pending_items[$];
	out_t share_expected[$];
	int mismatches;
	int results_seen;
	int items_sent;
	longint unsigned cycles;
	bit sender_hold;
	int long_stall;

	// split one secret into its expected shares under the current registers
	function automatic out_t compute_shares(in_t it);
		out_t r;
		logic [63:0] keep;
		logic [63:0] word;
		logic [XW:0] sum;
		logic [63:0] mask;
		logic [63:0] quot;
		int nb;
		nb = (nbytes_reg > 8) ? 8 : nbytes_reg;
		keep = (nb >= 8) ? '1 : ((64'd1 << (8 * nb)) - 64'd1);
		word = it.key_word & keep;
		if (prime_reg == 0)
			mask = {2'b00, word[XW-1:0]};
		else
			mask = word % {2'b00, prime_reg};
		sum = {1'b0, it.secret_value} + mask[XW:0];
		if (prime_reg == 0) begin
			r.share_residue = sum[XW-1:0];
			quot = {63'd0, sum[XW]};
		end else begin
			r.share_residue = XW'({1'b0, sum} % {2'b00, prime_reg});
			quot = {1'b0, sum} / {2'b00, prime_reg};
		end
		r.flip_bit = it.flip_byte[0];
		r.share_bit = quot[0] ^ it.flip_byte[0];
		r.mask_value = mask[XW-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("mismatch on %s at result %0d: got %h expected %h", field, results_seen,
			got, want);
		mismatches++;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// driver: bursts of transfers with random gaps
	int burst_left;
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				// transfer done, predict it now
				share_expected.push_back(compute_shares(in_ch.data));
				items_sent++;
			end
			if (!(in_ch.valid && !in_ch.ready)) begin
				if (gap_left > 0) begin
					gap_left--;
					in_ch.valid <= 1'b0;
				end else if (pending_items.size() > 0 && !sender_hold) begin
					in_ch.valid <= 1'b1;
					in_ch.data <= pending_items.pop_front();
					if (burst_left > 0)
						burst_left--;
					else begin
						burst_left = $urandom_range(40, 0);
						gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
					end
				end else
					in_ch.valid <= 1'b0;
			end
		end
	end

	// monitor and receiver stall pattern
	int stall_phase;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_phase = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				out_t want;
				if (share_expected.size() == 0) begin
					report_mismatch("unexpected result", 64'd1, 64'd0);
				end else begin
					want = share_expected.pop_front();
					if (out_ch.data.share_bit !== want.share_bit)
						report_mismatch("share_bit", 64'(out_ch.data.share_bit),
							64'(want.share_bit));
					if (out_ch.data.share_residue !== want.share_residue)
						report_mismatch("share_residue", 64'(out_ch.data.share_residue),
							64'(want.share_residue));
					if (out_ch.data.mask_value !== want.mask_value)
						report_mismatch("mask_value", 64'(out_ch.data.mask_value),
							64'(want.mask_value));
					if (out_ch.data.flip_bit !== want.flip_bit)
						report_mismatch("flip_bit", 64'(out_ch.data.flip_bit),
							64'(want.flip_bit));
				end
				results_seen++;
			end
			stall_phase = (stall_phase + 1) % 97;
			if (long_stall > 0) begin
				long_stall--;
				out_ch.ready <= 1'b0;
			end else if (stall_phase < 30)
				out_ch.ready <= 1'b1;
			else
				out_ch.ready <= ($urandom_range(2, 0) != 0);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("modular_additive_share_gen_core_tb failed");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MODULUS)
			prime_reg = val;
		else
			nbytes_reg = val[3:0];
	endtask

	task automatic wait_drained();
		while (pending_items.size() > 0 || in_ch.valid || share_expected.size() > 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// secrets near the interesting ends of the range, or random
	function automatic logic [XW-1:0] pick_secret();
		case ($urandom_range(4, 0))
			0: return '0;
			1: return '1;
			2: return prime_reg - XW'($urandom_range(3, 0));
			default: return XW'(rand64());
		endcase
	endfunction

	function automatic logic [63:0] pick_key();
		case ($urandom_range(5, 0))
			0: return '0;
			1: return '1;
			default: return rand64();
		endcase
	endfunction

	task automatic queue_random(int n);
		in_t it;
		for (int i = 0; i < n; i++) begin
			it.secret_value = pick_secret();
			it.key_word = pick_key();
			it.flip_byte = 8'($urandom_range(255, 0));
			pending_items.push_back(it);
		end
	endtask

	// modulus settings; zero and one are the special cases, the rest extremes and primes
	logic [XW-1:0] prime_set[8] = '{62'd0, 62'd1, 62'd2, 62'd251,
		62'h3FFF_FFFF_FFFF_FFFF, 62'd2305843009213693951, 62'd4294967291,
		62'd4611686018427387847};

	initial begin
		in_t it;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		prime_reg = MODULUS_RST;
		nbytes_reg = KEY_BYTES_RST;
		mismatches = 0;
		results_seen = 0;
		items_sent = 0;
		cycles = 0;
		sender_hold = 1'b0;
		long_stall = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed part under reset registers: field extremes
		it = '{secret_value: '0, key_word: '0, flip_byte: 8'h00};
		pending_items.push_back(it);
		it = '{secret_value: '1, key_word: '1, flip_byte: 8'hFF};
		pending_items.push_back(it);
		it = '{secret_value: MODULUS_RST - 1, key_word: 64'd1, flip_byte: 8'h01};
		pending_items.push_back(it);
		it = '{secret_value: '1, key_word: 64'h5555_5555_5555_5555, flip_byte: 8'hFE};
		pending_items.push_back(it);
		it = '{secret_value: 62'h2AAA_AAAA_AAAA_AAAA, key_word: 64'hAAAA_AAAA_AAAA_AAAA,
			flip_byte: 8'h55};
		pending_items.push_back(it);
		wait_drained();

		// zero key bytes, counts below eight, and key byte counts above eight that saturate
		for (int k = 0; k < 16; k += 3) begin
			write_reg(REG_KEY_BYTES, CFG_DATA_W'(k));
			it = '{secret_value: '1, key_word: '1, flip_byte: 8'h01};
			pending_items.push_back(it);
			wait_drained();
		end
		write_reg(REG_KEY_BYTES, CFG_DATA_W'(15));
		queue_random(5);
		wait_drained();

		// random phases across modulus and key byte settings
		for (int ph = 0; ph < 16; ph++) begin
			write_reg(REG_MODULUS, prime_set[ph % 8]);
			write_reg(REG_KEY_BYTES, CFG_DATA_W'($urandom_range(15, 0)));
			queue_random(90);
			if (ph == 3) begin
				// more items than the pipeline holds, then hold the receiver off
				// so the pipeline and the queue fill and the input stalls
				queue_random(150);
				long_stall = 2 * LATENCY + 50;
			end
			if (ph == 6) begin
				// sender pauses mid-phase until everything is back
				while (pending_items.size() > 45) @(posedge clk);
				sender_hold = 1'b1;
				while (share_expected.size() > 0 || in_ch.valid) @(posedge clk);
				sender_hold = 1'b0;
			end
			wait_drained();
		end

		$display("covered %0d items over %0d modulus settings with key byte counts 0 to 15",
			items_sent, 8);
		$display("results checked: %0d, mismatches: %0d", results_seen, mismatches);
		if (mismatches == 0)
			$display("modular_additive_share_gen_core_tb passed");
		else
			$display("modular_additive_share_gen_core_tb failed");
		$finish;
	end

endmodule
